@@ design/radix_prefixed_integer_parser_macros.svh @@
// Assertion macros shared by the integer literal parser RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef RADIX_PREFIXED_INTEGER_PARSER_MACROS_SVH
`define RADIX_PREFIXED_INTEGER_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RPIP_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RPIP_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/rpip_pkg.sv @@
// Types and constants for the integer literal parser.
// No dependencies; used by every module.
package rpip_pkg;

    localparam int COUNT_BITS_DEF = 16;

    // classified-character queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic [1:0] MODE_PREFIX = 2'd0;
    localparam logic [1:0] MODE_DEC    = 2'd1;
    localparam logic [1:0] MODE_SIGNED = 2'd2;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_LO    = 8'h6f;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;

    typedef enum logic [1:0] {
        RX_BIN = 2'd0,
        RX_OCT = 2'd1,
        RX_DEC = 2'd2,
        RX_HEX = 2'd3
    } radix_t;

    typedef enum logic [3:0] {
        PH_START  = 4'b0001,
        PH_ZERO   = 4'b0010,
        PH_DIGITS = 4'b0100,
        PH_SKIP   = 4'b1000
    } phase_t;

    // one character after classification
    typedef struct packed {
        logic [3:0] digit;       // value of 0-9, a-f, A-F
        logic       is_digit;    // any hex digit
        logic       is_zero;
        logic       is_minus;
        logic       is_prefix;   // b, o or x
        radix_t     prefix_radix;
        logic       last;
    } rpip_class_t;

endpackage

@@ design/rpip_if.sv @@
// Handshake channels of the integer literal parser: characters, results, configuration.
// Depends on nothing; one request moves when valid and ready are both high.
interface rpip_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last_char;

    modport source (output valid, output character, output last_char, input ready);
    modport sink   (input valid, input character, input last_char, output ready);
endinterface

interface rpip_result_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic [15:0] consumed;
    logic [1:0]  radix_code;

    modport source (output valid, output value, output consumed, output radix_code,
                    input ready);
    modport sink   (input valid, input value, input consumed, input radix_code,
                    output ready);
endinterface

interface rpip_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/rpip_front.sv @@
// Front end: takes character requests and classifies each byte.
// Depends on rpip_pkg and rpip_char_if; feeds rpip_queue.
module rpip_front (
    rpip_char_if.sink           chars,
    input  logic                full,
    output logic                push,
    output rpip_pkg::rpip_class_t item
);
    import rpip_pkg::*;

    logic       is_dec;
    logic       is_lower;
    logic       is_upper;
    logic [7:0] c;

    assign c        = chars.character;
    assign is_dec   = (c >= CH_0) && (c <= CH_9);
    assign is_lower = (c >= CH_LA) && (c <= CH_LF);
    assign is_upper = (c >= CH_UA) && (c <= CH_UF);

    assign chars.ready = !full;
    assign push        = chars.valid && !full;

    always_comb
    begin
        item = '0;
        priority if (is_dec)
            item.digit = 4'(c - CH_0);
        else if (is_lower)
            item.digit = 4'((c - CH_LA) + 8'd10);
        else if (is_upper)
            item.digit = 4'((c - CH_UA) + 8'd10);
        else
            item.digit = 4'd0;
        item.is_digit  = is_dec || is_lower || is_upper;
        item.is_zero   = (c == CH_0);
        item.is_minus  = (c == CH_MINUS);
        item.is_prefix = (c == CH_LB) || (c == CH_LO) || (c == CH_LX);
        priority if (c == CH_LB)
            item.prefix_radix = RX_BIN;
        else if (c == CH_LO)
            item.prefix_radix = RX_OCT;
        else
            item.prefix_radix = RX_HEX;
        item.last = chars.last_char;
    end

endmodule

@@ design/rpip_queue.sv @@
// Short queue of classified characters between front and back.
// Depends on rpip_pkg and the assertion macros.
`include "radix_prefixed_integer_parser_macros.svh"

module rpip_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  rpip_pkg::rpip_class_t push_item,
    output logic                  full,
    input  logic                  pop,
    output logic                  not_empty,
    output rpip_pkg::rpip_class_t head
);
    import rpip_pkg::*;

    rpip_class_t         mem_reg [Q_DEPTH];
    logic [Q_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [Q_CW-1:0]     count_reg, count_next;

    assign full      = (count_reg == Q_CW'(Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + Q_CW'(push) - Q_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    `RPIP_ASSERT_IMPL(a_q_no_overrun, clk, rst_n, full, !push, "push into full queue")
    `RPIP_ASSERT_NEXT(a_q_fill, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 1'b1, "queue count did not rise")

endmodule

@@ design/rpip_back.sv @@
// Back end: parse state machine, accumulator and result register.
// Depends on rpip_pkg, rpip_result_if and the assertion macros.
`include "radix_prefixed_integer_parser_macros.svh"

module rpip_back #(
    parameter int COUNT_BITS = rpip_pkg::COUNT_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [1:0]            mode,
    input  logic                  q_valid,
    input  rpip_pkg::rpip_class_t q_item,
    output logic                  q_pop,
    rpip_result_if.source         result
);
    import rpip_pkg::*;

    localparam int CW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    phase_t                phase_reg, phase_next;
    logic [63:0]           acc_reg, acc_next;
    logic [63:0]           nacc_reg, nacc_next;   // negated accumulator, kept alongside
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    radix_t                radix_reg, radix_next;
    logic                  neg_reg, neg_next;
    logic                  emit;

    logic                  out_valid_reg;
    logic [63:0]           out_value_reg;
    logic [15:0]           out_consumed_reg;
    radix_t                out_radix_reg;

    function automatic logic [63:0] scale(input logic [63:0] a, input radix_t rx);
        logic [63:0] r;
        unique case (rx)
            RX_BIN:  r = a << 1;
            RX_OCT:  r = a << 3;
            RX_DEC:  r = (a << 3) + (a << 1);
            RX_HEX:  r = a << 4;
            default: r = a;
        endcase
        return r;
    endfunction

    function automatic logic digit_fits(input rpip_class_t it, input radix_t rx);
        logic ok;
        unique case (rx)
            RX_BIN:  ok = it.is_digit && (it.digit < 4'd2);
            RX_OCT:  ok = it.is_digit && (it.digit < 4'd8);
            RX_DEC:  ok = it.is_digit && (it.digit < 4'd10);
            RX_HEX:  ok = it.is_digit;
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

    assign q_pop = q_valid && (!out_valid_reg || result.ready);

    always_comb
    begin
        logic                  at_start;
        logic [63:0]           acc_b;
        logic [63:0]           nacc_b;
        logic [COUNT_BITS-1:0] cnt_b;
        logic [COUNT_BITS-1:0] cnt_inc;
        radix_t                radix_b;
        logic                  neg_b;
        logic                  do_digit;
        logic                  ok;
        logic [63:0]           acc_dig;
        logic [63:0]           nacc_dig;

        // a fresh string starts from cleared state
        at_start = (phase_reg == PH_START);
        acc_b    = at_start ? 64'd0 : acc_reg;
        nacc_b   = at_start ? 64'd0 : nacc_reg;
        cnt_b    = at_start ? '0 : cnt_reg;
        radix_b  = at_start ? RX_DEC : radix_reg;
        neg_b    = at_start ? 1'b0 : neg_reg;

        cnt_inc  = (cnt_b == CNT_MAX) ? cnt_b : cnt_b + 1'b1;
        ok       = digit_fits(q_item, radix_b);
        acc_dig  = scale(acc_b, radix_b) + 64'(q_item.digit);
        nacc_dig = scale(nacc_b, radix_b) - 64'(q_item.digit);

        phase_next = phase_reg;
        acc_next   = acc_b;
        nacc_next  = nacc_b;
        cnt_next   = cnt_b;
        radix_next = radix_b;
        neg_next   = neg_b;
        emit       = 1'b0;
        do_digit   = 1'b0;

        unique case (phase_reg)
            PH_START:
            begin
                priority if (mode == MODE_PREFIX && q_item.is_zero && !q_item.last)
                begin
                    cnt_next   = cnt_inc;
                    phase_next = PH_ZERO;
                end
                else if (mode == MODE_SIGNED && q_item.is_minus)
                begin
                    neg_next   = 1'b1;
                    cnt_next   = cnt_inc;
                    phase_next = PH_DIGITS;
                    emit       = q_item.last;
                end
                else
                    do_digit = 1'b1;
            end
            PH_ZERO:
            begin
                // b is also a hex digit, so the prefix check wins
                if (q_item.is_prefix)
                begin
                    radix_next = q_item.prefix_radix;
                    cnt_next   = cnt_inc;
                    phase_next = PH_DIGITS;
                    emit       = q_item.last;
                end
                else
                    do_digit = 1'b1;
            end
            PH_DIGITS: do_digit = 1'b1;
            PH_SKIP:   emit = 1'b0;
            default:   phase_next = PH_START;
        endcase

        if (do_digit)
        begin
            if (ok)
            begin
                acc_next   = acc_dig;
                nacc_next  = nacc_dig;
                cnt_next   = cnt_inc;
                phase_next = PH_DIGITS;
                emit       = q_item.last;
            end
            else
            begin
                phase_next = PH_SKIP;
                emit       = 1'b1;
            end
        end

        if (q_item.last)
            phase_next = PH_START;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
                phase_reg <= phase_next;
            if (q_pop && emit)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        logic [CW-1:0] cnt_ext;
        cnt_ext = CW'(cnt_next);
        if (q_pop)
        begin
            acc_reg   <= acc_next;
            nacc_reg  <= nacc_next;
            cnt_reg   <= cnt_next;
            radix_reg <= radix_next;
            neg_reg   <= neg_next;
        end
        if (q_pop && emit)
        begin
            out_value_reg    <= neg_next ? nacc_next : acc_next;
            out_consumed_reg <= (cnt_ext > CW'(16'hffff)) ? 16'hffff : cnt_ext[15:0];
            out_radix_reg    <= radix_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.value      = out_value_reg;
    assign result.consumed   = out_consumed_reg;
    assign result.radix_code = out_radix_reg;

    `RPIP_ASSERT_IMPL(a_no_pop_on_stall, clk, rst_n, out_valid_reg && !result.ready, !q_pop, "queue popped while result stalled")
    `RPIP_ASSERT_IMPL(a_skip_silent, clk, rst_n, q_pop && phase_reg == PH_SKIP, !emit, "result from trailing text")
    `RPIP_ASSERT_NEXT(a_last_restarts, clk, rst_n, q_pop && q_item.last, phase_reg == PH_START, "string end did not restart parse")

endmodule

@@ design/radix_prefixed_integer_parser.sv @@
// Integer literal parser: one character per cycle unless stalled, one result per literal.
// Channels: chars (character, last_char) in, result (value, consumed, radix_code) out,
// cfg (parse_mode) in. A request moves when valid and ready are both high.
// The string's last character carries last_char = 1; the next character starts a new
// string. parse_mode is sampled at each string's first character: 0 accepts 0b/0o/0x
// prefixes, 1 (and 3) plain decimal, 2 decimal with an optional leading minus.
// Throughput: one character per cycle while the receiver takes results. The back end's
// accumulator shift-add is combinational. The character that ends the literal is written
// into the queue when accepted, then parsed and its result registered when the back end
// pops it; result.valid then rises.
// A two-entry queue between the classifier and the parse stage lets characters keep
// arriving while a result waits; when the receiver stalls the queue fills and
// chars.ready drops, with no character lost. Trailing characters after the literal
// still move through, producing nothing, up to the last one.
// Reset (rst_n low, asynchronous) empties the queue, drops any pending result, starts
// a new string and sets parse_mode to 0. No clearing pass is needed.
// cfg.ready is always high; write it only while the block is idle.
module radix_prefixed_integer_parser #(
    parameter int COUNT_BITS = rpip_pkg::COUNT_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    rpip_char_if.sink     chars,
    rpip_result_if.source result,
    rpip_cfg_if.sink      cfg
);
    import rpip_pkg::*;

    logic [1:0]  mode_reg;
    logic        push;
    logic        full;
    logic        pop;
    logic        not_empty;
    rpip_class_t push_item;
    rpip_class_t head;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_PREFIX;
        else if (cfg.valid)
            mode_reg <= cfg.data;
    end

    rpip_front u_front (
        .chars (chars),
        .full  (full),
        .push  (push),
        .item  (push_item)
    );

    rpip_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head)
    );

    rpip_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .mode    (mode_reg),
        .q_valid (not_empty),
        .q_item  (head),
        .q_pop   (pop),
        .result  (result)
    );

endmodule
